// File: hw/rtl/min_max_heap_priority_queue_defines.svh
// ----------------------------------------------------------------------------
// Min-max heap priority queue: assertion macros
// Concurrent assertion wrappers, clocked on clock and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef MIN_MAX_HEAP_PRIORITY_QUEUE_DEFINES_SVH
`define MIN_MAX_HEAP_PRIORITY_QUEUE_DEFINES_SVH

`ifndef SYNTHESIS
// Check that a property holds at every clock edge out of reset
`define MMHPQ_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);
// Check that a condition never occurs out of reset
`define MMHPQ_NEVER(lbl, expr, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) !(expr)) else $error(msg);
`else
`define MMHPQ_ASSERT(lbl, prop, msg)
`define MMHPQ_NEVER(lbl, expr, msg)
`endif

`endif

// File: hw/rtl/mmhpq_pkg.sv
// ----------------------------------------------------------------------------
// Min-max heap priority queue package
// Sizes, entry type, operation and status codes, and heap index helpers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package mmhpq_pkg;

   localparam int CAPACITY      = 128;
   localparam int PAYLOAD_WIDTH = 32;
   localparam int KEY_W         = 32;
   localparam int COUNT_W       = 8;
   localparam int IDX_W         = $clog2(CAPACITY);
   localparam int CNT_W         = $clog2(CAPACITY + 1);
   localparam int XW            = IDX_W + 3;
   localparam int ENTRY_W       = KEY_W + PAYLOAD_WIDTH;

   typedef logic [IDX_W-1:0] idx_type;
   typedef logic [CNT_W-1:0] cnt_type;
   typedef logic [XW-1:0]    xidx_type;
   typedef logic [2:0]       scan_type;

   // last candidate of a push-down scan: two children, four grandchildren
   localparam scan_type SCAN_LAST = 3'd5;
   localparam scan_type SCAN_GC0  = 3'd2;
   localparam scan_type SCAN_GC2  = 3'd4;

   typedef struct packed {
      logic signed [KEY_W-1:0]  key;
      logic [PAYLOAD_WIDTH-1:0] pay;
   } entry_type;

   typedef enum logic [1:0] {
      OP_INSERT     = 2'd0,
      OP_REMOVE_MIN = 2'd1,
      OP_REMOVE_MAX = 2'd2,
      OP_NONE       = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      STAT_OK    = 2'd0,
      STAT_FULL  = 2'd1,
      STAT_EMPTY = 2'd2
   } status_type;

   // On a min level "better" is smaller, on a max level larger
   function automatic logic better(logic signed [KEY_W-1:0] a,
                                   logic signed [KEY_W-1:0] b,
                                   logic minlvl);
      return minlvl ? (a < b) : (b < a);
   endfunction

   // Level of node i is the MSB position of i+1; even levels are min levels
   function automatic logic on_min_level(idx_type i);
      logic [IDX_W:0] n;
      logic           lvl_odd;
      n       = {1'b0, i} + {{IDX_W{1'b0}}, 1'b1};
      lvl_odd = 1'b0;
      for (int b = 0; b <= IDX_W; b++) begin
         if (n[b]) lvl_odd = b[0];
      end
      return !lvl_odd;
   endfunction

   // Push-down candidates: k 0..1 children 2i+1.., k 2..5 grandchildren 4i+3..
   function automatic xidx_type cand_idx(idx_type i, scan_type k);
      xidx_type iw;
      iw = xidx_type'(i);
      if (k < SCAN_GC0) begin
         return (iw << 1) + xidx_type'(1) + xidx_type'(k);
      end
      return (iw << 2) + xidx_type'(1) + xidx_type'(k);
   endfunction

endpackage

// File: hw/rtl/min_max_heap_priority_queue.sv
// ----------------------------------------------------------------------------
// Min-max heap priority queue
// Double-ended priority queue: insert, remove minimum, remove maximum, with
// the entries held in one RAM and a sequencer that walks the heap levels.
// ----------------------------------------------------------------------------
// Channel | Direction | Beat
// req_    | in        | op, key, payload
// rsp_    | out       | status, removed entry, count, current maximum entry
//
// One item at a time; every RAM access is one read or one write per cycle.
// Insert sifts up against the parent, then by grandparent steps.
// Removal ends in a push-down whose steps are start, up to six candidate
// reads, compare and parent swap; a step that goes on descends two levels.
// Reset clears the entry count and the sequencer; the RAM needs no clearing.
// A stalled result holds in the output register; the sequencer waits at the
// end of the next item until the register frees.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "min_max_heap_priority_queue_defines.svh"

module min_max_heap_priority_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [1:0]         req_op,
   input  logic signed [31:0] req_key,
   input  logic [31:0]        req_payload,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [1:0]         rsp_status,
   output logic signed [31:0] rsp_removed_key,
   output logic [31:0]        rsp_removed_payload,
   output logic [7:0]         rsp_count,
   output logic signed [31:0] rsp_max_key,
   output logic [31:0]        rsp_max_payload
);

   typedef enum logic [19:0] {
      ST_IDLE     = 20'h00001,
      ST_UP_P     = 20'h00002,
      ST_UP_PC    = 20'h00004,
      ST_UP_G     = 20'h00008,
      ST_UP_GC    = 20'h00010,
      ST_PLACE    = 20'h00020,
      ST_MI_R2    = 20'h00040,
      ST_MI_C     = 20'h00080,
      ST_RM_CAP   = 20'h00100,
      ST_RM_DEC   = 20'h00200,
      ST_RM_LAST  = 20'h00400,
      ST_DN_START = 20'h00800,
      ST_DN_SCAN  = 20'h01000,
      ST_DN_CMP   = 20'h02000,
      ST_DN_SWP   = 20'h04000,
      ST_MAX      = 20'h08000,
      ST_MAX_B    = 20'h10000,
      ST_MAX_C    = 20'h20000,
      ST_MAX_A1   = 20'h40000,
      ST_DONE     = 20'h80000
   } state_type;

   state_type              state_ff, state_in;
   mmhpq_pkg::cnt_type     cnt_ff, cnt_in;
   mmhpq_pkg::idx_type     i_ff, i_in;
   mmhpq_pkg::idx_type     swp_ff, swp_in;
   mmhpq_pkg::scan_type    scan_ff, scan_in;
   mmhpq_pkg::scan_type    bk_ff, bk_in;
   logic                   mn_ff, mn_in;
   mmhpq_pkg::entry_type   cur_ff, cur_in;
   mmhpq_pkg::entry_type   best_ff, best_in;
   mmhpq_pkg::entry_type   c1d_ff, c1d_in;
   mmhpq_pkg::entry_type   c2d_ff, c2d_in;
   mmhpq_pkg::entry_type   mx1_ff, mx1_in;
   mmhpq_pkg::entry_type   rem_ff, rem_in;
   mmhpq_pkg::entry_type   maxe_ff, maxe_in;
   mmhpq_pkg::status_type  status_ff, status_in;

   logic                   rsp_valid_ff, rsp_valid_in;
   mmhpq_pkg::status_type  rsp_status_ff, rsp_status_in;
   mmhpq_pkg::entry_type   rsp_rem_ff, rsp_rem_in;
   mmhpq_pkg::entry_type   rsp_max_ff, rsp_max_in;
   logic [7:0]             rsp_cnt_ff, rsp_cnt_in;

   logic                   ram_wr_en;
   mmhpq_pkg::idx_type     ram_wr_addr;
   mmhpq_pkg::entry_type   ram_wr_data;
   mmhpq_pkg::idx_type     ram_rd_addr;
   mmhpq_pkg::entry_type   ram_rd_data;

   logic                   accept;
   logic                   full_insert;
   mmhpq_pkg::idx_type     par_idx;
   mmhpq_pkg::idx_type     gpar_idx;
   mmhpq_pkg::cnt_type     cnt_dec;
   mmhpq_pkg::xidx_type    cnt_x;
   mmhpq_pkg::xidx_type    next_cand;
   mmhpq_pkg::xidx_type    best_cand;
   mmhpq_pkg::entry_type   pdata;
   mmhpq_pkg::idx_type     pidx;

   mmhpq_ram #(
      .DEPTH (mmhpq_pkg::CAPACITY),
      .WIDTH (mmhpq_pkg::ENTRY_W)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign req_ready   = (state_ff == ST_IDLE);
   assign accept      = req_valid && req_ready;
   assign full_insert = accept && (req_op == mmhpq_pkg::OP_INSERT) &&
                        (cnt_ff == mmhpq_pkg::cnt_type'(mmhpq_pkg::CAPACITY));

   // Index arithmetic of the current node
   assign par_idx   = (i_ff - mmhpq_pkg::idx_type'(1)) >> 1;
   assign gpar_idx  = (i_ff - mmhpq_pkg::idx_type'(3)) >> 2;
   assign cnt_dec   = cnt_ff - mmhpq_pkg::cnt_type'(1);
   assign cnt_x     = mmhpq_pkg::xidx_type'(cnt_ff);
   assign next_cand = mmhpq_pkg::cand_idx(i_ff, scan_ff + mmhpq_pkg::scan_type'(1));
   assign best_cand = mmhpq_pkg::cand_idx(i_ff, bk_ff);
   assign pdata     = (bk_ff < mmhpq_pkg::SCAN_GC2) ? c1d_ff : c2d_ff;
   assign pidx      = mmhpq_pkg::idx_type'(mmhpq_pkg::cand_idx(i_ff,
                        (bk_ff < mmhpq_pkg::SCAN_GC2) ? 3'd0 : 3'd1));

   // Sequencer
   always_comb begin
      state_in    = state_ff;
      cnt_in      = cnt_ff;
      i_in        = i_ff;
      swp_in      = swp_ff;
      scan_in     = scan_ff;
      bk_in       = bk_ff;
      mn_in       = mn_ff;
      cur_in      = cur_ff;
      best_in     = best_ff;
      c1d_in      = c1d_ff;
      c2d_in      = c2d_ff;
      mx1_in      = mx1_ff;
      rem_in      = rem_ff;
      maxe_in     = maxe_ff;
      status_in   = status_ff;
      ram_wr_en   = 1'b0;
      ram_wr_addr = i_ff;
      ram_wr_data = cur_ff;
      ram_rd_addr = '0;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_status_in = rsp_status_ff;
      rsp_rem_in    = rsp_rem_ff;
      rsp_max_in    = rsp_max_ff;
      rsp_cnt_in    = rsp_cnt_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               status_in = mmhpq_pkg::STAT_OK;
               rem_in    = '0;
               case (req_op) inside
                  mmhpq_pkg::OP_INSERT: begin
                     if (full_insert) begin
                        status_in = mmhpq_pkg::STAT_FULL;
                        state_in  = ST_MAX;
                     end else begin
                        cur_in.key = req_key;
                        cur_in.pay = req_payload[mmhpq_pkg::PAYLOAD_WIDTH-1:0];
                        i_in       = mmhpq_pkg::idx_type'(cnt_ff);
                        cnt_in     = cnt_ff + mmhpq_pkg::cnt_type'(1);
                        state_in   = ST_UP_P;
                     end
                  end
                  mmhpq_pkg::OP_REMOVE_MIN, mmhpq_pkg::OP_REMOVE_MAX: begin
                     if (cnt_ff == '0) begin
                        status_in = mmhpq_pkg::STAT_EMPTY;
                        state_in  = ST_MAX;
                     end else if (req_op == mmhpq_pkg::OP_REMOVE_MAX &&
                                  cnt_ff > mmhpq_pkg::cnt_type'(2)) begin
                        ram_rd_addr = mmhpq_pkg::idx_type'(1);
                        state_in    = ST_MI_R2;
                     end else begin
                        // max of a two-entry heap sits at node 1
                        if (req_op == mmhpq_pkg::OP_REMOVE_MAX &&
                            cnt_ff == mmhpq_pkg::cnt_type'(2)) begin
                           i_in = mmhpq_pkg::idx_type'(1);
                        end else begin
                           i_in = '0;
                        end
                        ram_rd_addr = i_in;
                        state_in    = ST_RM_CAP;
                     end
                  end
                  default: state_in = ST_MAX;
               endcase
            end
         end

         // Sift up: first against the parent, then along grandparents
         ST_UP_P: begin
            if (i_ff == '0) begin
               state_in = ST_PLACE;
            end else begin
               ram_rd_addr = par_idx;
               mn_in       = mmhpq_pkg::on_min_level(i_ff);
               state_in    = ST_UP_PC;
            end
         end
         ST_UP_PC: begin
            if (mmhpq_pkg::better(cur_ff.key, ram_rd_data.key, !mn_ff)) begin
               ram_wr_en   = 1'b1;
               ram_wr_data = ram_rd_data;
               i_in        = par_idx;
               mn_in       = !mn_ff;
            end
            state_in = ST_UP_G;
         end
         ST_UP_G: begin
            if (i_ff < mmhpq_pkg::idx_type'(3)) begin
               state_in = ST_PLACE;
            end else begin
               ram_rd_addr = gpar_idx;
               state_in    = ST_UP_GC;
            end
         end
         ST_UP_GC: begin
            if (mmhpq_pkg::better(cur_ff.key, ram_rd_data.key, mn_ff)) begin
               ram_wr_en   = 1'b1;
               ram_wr_data = ram_rd_data;
               i_in        = gpar_idx;
               state_in    = ST_UP_G;
            end else begin
               state_in = ST_PLACE;
            end
         end
         ST_PLACE: begin
            ram_wr_en = 1'b1;
            state_in  = ST_MAX;
         end

         // Pick the larger of nodes 1 and 2 for remove maximum
         ST_MI_R2: begin
            mx1_in      = ram_rd_data;
            ram_rd_addr = mmhpq_pkg::idx_type'(2);
            state_in    = ST_MI_C;
         end
         ST_MI_C: begin
            if (mx1_ff.key < ram_rd_data.key) begin
               i_in   = mmhpq_pkg::idx_type'(2);
               rem_in = ram_rd_data;
            end else begin
               i_in   = mmhpq_pkg::idx_type'(1);
               rem_in = mx1_ff;
            end
            state_in = ST_RM_DEC;
         end
         ST_RM_CAP: begin
            rem_in   = ram_rd_data;
            state_in = ST_RM_DEC;
         end

         // Drop the count and, unless the hole is the last entry, fetch that entry to refill it
         ST_RM_DEC: begin
            cnt_in = cnt_dec;
            if (mmhpq_pkg::cnt_type'(i_ff) < cnt_dec) begin
               ram_rd_addr = mmhpq_pkg::idx_type'(cnt_dec);
               state_in    = ST_RM_LAST;
            end else begin
               state_in = ST_MAX;
            end
         end
         ST_RM_LAST: begin
            cur_in   = ram_rd_data;
            state_in = ST_DN_START;
         end

         // Push down: scan children, then grandchildren
         ST_DN_START: begin
            mn_in = mmhpq_pkg::on_min_level(i_ff);
            if (mmhpq_pkg::cand_idx(i_ff, '0) >= cnt_x) begin
               state_in = ST_PLACE;
            end else begin
               ram_rd_addr = mmhpq_pkg::idx_type'(mmhpq_pkg::cand_idx(i_ff, '0));
               scan_in     = '0;
               state_in    = ST_DN_SCAN;
            end
         end
         ST_DN_SCAN: begin
            if (scan_ff == '0) begin
               best_in = ram_rd_data;
               bk_in   = '0;
               c1d_in  = ram_rd_data;
            end else if (mmhpq_pkg::better(ram_rd_data.key, best_ff.key, mn_ff)) begin
               best_in = ram_rd_data;
               bk_in   = scan_ff;
            end
            if (scan_ff == mmhpq_pkg::scan_type'(1)) c2d_in = ram_rd_data;
            if (scan_ff != mmhpq_pkg::SCAN_LAST && next_cand < cnt_x) begin
               ram_rd_addr = mmhpq_pkg::idx_type'(next_cand);
               scan_in     = scan_ff + mmhpq_pkg::scan_type'(1);
            end else begin
               state_in = ST_DN_CMP;
            end
         end
         ST_DN_CMP: begin
            if (mmhpq_pkg::better(best_ff.key, cur_ff.key, mn_ff)) begin
               ram_wr_en   = 1'b1;
               ram_wr_data = best_ff;
               i_in        = mmhpq_pkg::idx_type'(best_cand);
               if (bk_ff < mmhpq_pkg::SCAN_GC0) begin
                  state_in = ST_PLACE;
               end else if (mmhpq_pkg::better(pdata.key, cur_ff.key, mn_ff)) begin
                  swp_in   = pidx;
                  state_in = ST_DN_SWP;
               end else begin
                  state_in = ST_DN_START;
               end
            end else begin
               state_in = ST_PLACE;
            end
         end
         ST_DN_SWP: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = swp_ff;
            cur_in      = pdata;
            state_in    = ST_DN_START;
         end

         // Look up the current maximum entry
         ST_MAX: begin
            if (cnt_ff == '0) begin
               maxe_in  = '0;
               state_in = ST_DONE;
            end else if (cnt_ff == mmhpq_pkg::cnt_type'(1)) begin
               ram_rd_addr = '0;
               state_in    = ST_MAX_A1;
            end else if (cnt_ff == mmhpq_pkg::cnt_type'(2)) begin
               ram_rd_addr = mmhpq_pkg::idx_type'(1);
               state_in    = ST_MAX_A1;
            end else begin
               ram_rd_addr = mmhpq_pkg::idx_type'(1);
               state_in    = ST_MAX_B;
            end
         end
         ST_MAX_B: begin
            mx1_in      = ram_rd_data;
            ram_rd_addr = mmhpq_pkg::idx_type'(2);
            state_in    = ST_MAX_C;
         end
         ST_MAX_C: begin
            maxe_in  = (mx1_ff.key < ram_rd_data.key) ? ram_rd_data : mx1_ff;
            state_in = ST_DONE;
         end
         ST_MAX_A1: begin
            maxe_in  = ram_rd_data;
            state_in = ST_DONE;
         end

         // Hand the beat to the output register once it is free
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_ff;
               rsp_rem_in    = rem_ff;
               rsp_max_in    = maxe_ff;
               rsp_cnt_in    = 8'(cnt_ff);
               state_in      = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      i_ff          <= i_in;
      swp_ff        <= swp_in;
      scan_ff       <= scan_in;
      bk_ff         <= bk_in;
      mn_ff         <= mn_in;
      cur_ff        <= cur_in;
      best_ff       <= best_in;
      c1d_ff        <= c1d_in;
      c2d_ff        <= c2d_in;
      mx1_ff        <= mx1_in;
      rem_ff        <= rem_in;
      maxe_ff       <= maxe_in;
      status_ff     <= status_in;
      rsp_status_ff <= rsp_status_in;
      rsp_rem_ff    <= rsp_rem_in;
      rsp_max_ff    <= rsp_max_in;
      rsp_cnt_ff    <= rsp_cnt_in;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_status          = rsp_status_ff;
   assign rsp_removed_key     = rsp_rem_ff.key;
   assign rsp_removed_payload = rsp_rem_ff.pay;
   assign rsp_count           = rsp_cnt_ff;
   assign rsp_max_key         = rsp_max_ff.key;
   assign rsp_max_payload     = rsp_max_ff.pay;

   // Assertions
   `MMHPQ_ASSERT(a_wr_below_count, ram_wr_en |-> (ram_wr_addr < cnt_ff), "heap write beyond count")
   `MMHPQ_NEVER(a_count_range, cnt_ff > mmhpq_pkg::CAPACITY, "entry count above capacity")
   `MMHPQ_ASSERT(a_full_hold, full_insert |=> (cnt_ff == $past(cnt_ff)), "refused insert changed count")

endmodule

// File: hw/rtl/mmhpq_ram.sv
// ----------------------------------------------------------------------------
// Heap entry memory
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mmhpq_ram #(
   parameter int DEPTH  = 128,
   parameter int WIDTH  = 64,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
   end

   // Read port, registered data
   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: tb/min_max_heap_priority_queue_checker.sv
// ----------------------------------------------------------------------------
// Min-max heap priority queue: result checker
// Watches the request and response channels, keeps its own min-max heap to
// predict each response, and compares the responses field by field in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module min_max_heap_priority_queue_checker (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_ready,
   input  logic [1:0]         req_op,
   input  logic signed [31:0] req_key,
   input  logic [31:0]        req_payload,
   input  logic               rsp_valid,
   input  logic               rsp_ready,
   input  logic [1:0]         rsp_status,
   input  logic signed [31:0] rsp_removed_key,
   input  logic [31:0]        rsp_removed_payload,
   input  logic [7:0]         rsp_count,
   input  logic signed [31:0] rsp_max_key,
   input  logic [31:0]        rsp_max_payload,
   output int                 fail_count,
   output int                 pending_count
);

   typedef struct packed {
      logic signed [31:0] key;
      logic [31:0]        pay;
   } slot_type;

   typedef struct packed {
      logic [1:0]         status;
      logic signed [31:0] rkey;
      logic [31:0]        rpay;
      logic [7:0]         count;
      logic signed [31:0] mkey;
      logic [31:0]        mpay;
   } outcome_type;

   slot_type    slots [mmhpq_pkg::CAPACITY];
   int          fill;
   outcome_type expected_q[$];

   assign pending_count = expected_q.size();

   function automatic bit is_min_level(int i);
      int n, lvl;
      n   = i + 1;
      lvl = 0;
      while (n > 1) begin
         n >>= 1;
         lvl++;
      end
      return (lvl % 2) == 0;
   endfunction

   function automatic bit wins(int a, int b, bit minlvl);
      return minlvl ? (slots[a].key < slots[b].key) : (slots[b].key < slots[a].key);
   endfunction

   function automatic void trade(int a, int b);
      slot_type t;
      t        = slots[a];
      slots[a] = slots[b];
      slots[b] = t;
   endfunction

   function automatic void climb(int i);
      bit mn;
      int g;
      if (i == 0) return;
      mn = is_min_level(i);
      if (wins(i, (i - 1) / 2, !mn)) begin
         trade(i, (i - 1) / 2);
         i  = (i - 1) / 2;
         mn = !mn;
      end
      while (i >= 3) begin
         g = ((i - 1) / 2 - 1) / 2;
         if (!wins(i, g, mn)) break;
         trade(i, g);
         i = g;
      end
   endfunction

   function automatic void sink(int i);
      bit mn;
      int m, p;
      forever begin
         mn = is_min_level(i);
         if (2 * i + 1 >= fill) return;
         m = 2 * i + 1;
         if (m + 1 < fill && wins(m + 1, m, mn)) m = m + 1;
         for (int k = 4 * i + 3; k <= 4 * i + 6; k++)
            if (k < fill && wins(k, m, mn)) m = k;
         if (!wins(m, i, mn)) return;
         trade(m, i);
         if (m < 4 * i + 3) return;
         p = (m - 1) / 2;
         if (wins(p, m, mn)) trade(m, p);
         i = m;
      end
   endfunction

   function automatic int top_index();
      if (fill <= 1) return 0;
      if (fill == 2) return 1;
      return (slots[1].key < slots[2].key) ? 2 : 1;
   endfunction

   // Apply one request beat to the shadow heap and return the response
   function automatic outcome_type apply_request(logic [1:0] op, logic signed [31:0] key,
                                                 logic [31:0] pay);
      outcome_type o;
      int idx;
      o = '0;
      if (op == mmhpq_pkg::OP_INSERT) begin
         if (fill >= mmhpq_pkg::CAPACITY) o.status = mmhpq_pkg::STAT_FULL;
         else begin
            slots[fill] = '{key, pay};
            fill++;
            climb(fill - 1);
         end
      end else if (op == mmhpq_pkg::OP_REMOVE_MIN || op == mmhpq_pkg::OP_REMOVE_MAX) begin
         if (fill == 0) o.status = mmhpq_pkg::STAT_EMPTY;
         else begin
            idx    = (op == mmhpq_pkg::OP_REMOVE_MIN) ? 0 : top_index();
            o.rkey = slots[idx].key;
            o.rpay = slots[idx].pay;
            fill--;
            if (idx < fill) begin
               slots[idx] = slots[fill];
               sink(idx);
            end
         end
      end
      if (fill > 0) begin
         idx    = top_index();
         o.mkey = slots[idx].key;
         o.mpay = slots[idx].pay;
      end
      o.count = fill[7:0];
      return o;
   endfunction

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      $display("%0t mismatch %s: got %0h expected %0h", $realtime, what, got, want);
      fail_count++;
   endtask

   // Predict on request beats, compare on response beats
   always @(posedge clock) begin
      outcome_type w;
      if (reset) begin
         fill       = 0;
         fail_count = 0;
         expected_q.delete();
      end else begin
         if (req_valid && req_ready)
            expected_q.push_back(apply_request(req_op, req_key, req_payload));
         if (rsp_valid && rsp_ready) begin
            if (expected_q.size() == 0) begin
               report_mismatch("unexpected beat", 32'(rsp_status), '0);
            end else begin
               w = expected_q.pop_front();
               if (rsp_status != w.status)
                  report_mismatch("status", 32'(rsp_status), 32'(w.status));
               if (rsp_removed_key != w.rkey)
                  report_mismatch("removed_key", rsp_removed_key, w.rkey);
               if (rsp_removed_payload != w.rpay)
                  report_mismatch("removed_payload", rsp_removed_payload, w.rpay);
               if (rsp_count != w.count)
                  report_mismatch("count", 32'(rsp_count), 32'(w.count));
               if (rsp_max_key != w.mkey) report_mismatch("max_key", rsp_max_key, w.mkey);
               if (rsp_max_payload != w.mpay)
                  report_mismatch("max_payload", rsp_max_payload, w.mpay);
            end
         end
      end
   end

endmodule

// File: tb/min_max_heap_priority_queue_test.sv
// ----------------------------------------------------------------------------
// Min-max heap priority queue testbench
// Drives directed and random insert/remove beats with varied idling and a
// long response hold-off; the checker predicts and compares every response.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module min_max_heap_priority_queue_test;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic [1:0]         req_op = mmhpq_pkg::OP_NONE;
   logic signed [31:0] req_key = '0;
   logic [31:0]        req_payload = '0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic [1:0]         rsp_status;
   logic signed [31:0] rsp_removed_key;
   logic [31:0]        rsp_removed_payload;
   logic [7:0]         rsp_count;
   logic signed [31:0] rsp_max_key;
   logic [31:0]        rsp_max_payload;
   int                 fail_count, pending_count;
   int                 send_idle_pct = 0;
   int                 recv_stall_pct = 0;
   bit                 hold_off = 1'b0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   min_max_heap_priority_queue dut (.*);

   min_max_heap_priority_queue_checker checker_i (.*);

   // Response ready: random stall, or held low for a long stretch
   always @(posedge clock) begin
      if (reset) rsp_ready <= 1'b0;
      else rsp_ready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
   end

   // Offer one beat; valid drops only when an idle gap comes before it
   task automatic send_beat(logic [1:0] op, logic signed [31:0] key, logic [31:0] pay);
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
         while ($urandom_range(99) < send_idle_pct) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_op      <= op;
      req_key     <= key;
      req_payload <= pay;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   // Random key: often from a narrow range for ties, sometimes extreme
   function automatic logic signed [31:0] pick_key();
      case ($urandom_range(3))
         0: return $urandom;
         1: return $urandom_range(3) - 2;
         2: return $urandom_range(1) ? 32'sh7fffffff : 32'sh80000000;
         default: return $urandom_range(40) - 20;
      endcase
   endfunction

   // Random beat: insert-heavy while filling, removal-heavy while draining
   task automatic random_beat(int insert_pct);
      int r;
      logic [1:0] op;
      r = $urandom_range(99);
      if (r < insert_pct) op = mmhpq_pkg::OP_INSERT;
      else if (r < 98)
         op = $urandom_range(1) ? mmhpq_pkg::OP_REMOVE_MIN : mmhpq_pkg::OP_REMOVE_MAX;
      else op = mmhpq_pkg::OP_NONE;
      send_beat(op, pick_key(), $urandom);
   endtask

   initial begin
      #10_000_000;
      $display("[min_max_heap_priority_queue] ERROR");
      $finish;
   end

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: empty removals, extremes, ties, unused op
      send_beat(mmhpq_pkg::OP_REMOVE_MIN, 0, 0);
      send_beat(mmhpq_pkg::OP_REMOVE_MAX, 0, 0);
      send_beat(mmhpq_pkg::OP_NONE, 32'sh7fffffff, '1);
      send_beat(mmhpq_pkg::OP_INSERT, 32'sh7fffffff, '1);
      send_beat(mmhpq_pkg::OP_INSERT, 32'sh80000000, '0);
      send_beat(mmhpq_pkg::OP_INSERT, 0, 32'h5555_5555);
      send_beat(mmhpq_pkg::OP_INSERT, 0, 32'haaaa_aaaa);
      send_beat(mmhpq_pkg::OP_INSERT, 32'sh7fffffff, 32'h1);
      send_beat(mmhpq_pkg::OP_INSERT, -1, 32'h2);
      send_beat(mmhpq_pkg::OP_REMOVE_MAX, 0, 0);
      send_beat(mmhpq_pkg::OP_REMOVE_MAX, 0, 0);
      send_beat(mmhpq_pkg::OP_REMOVE_MIN, 0, 0);
      send_beat(mmhpq_pkg::OP_NONE, 0, 0);
      send_beat(mmhpq_pkg::OP_REMOVE_MIN, 0, 0);
      send_beat(mmhpq_pkg::OP_REMOVE_MAX, 0, 0);
      send_beat(mmhpq_pkg::OP_REMOVE_MIN, 0, 0);
      send_beat(mmhpq_pkg::OP_REMOVE_MIN, 0, 0);

      // Fill past capacity with the response held off, then drain
      fork
         begin
            hold_off = 1'b1;
            repeat (3000) @(posedge clock);
            hold_off = 1'b0;
         end
         repeat (mmhpq_pkg::CAPACITY + 4)
            send_beat(mmhpq_pkg::OP_INSERT, pick_key(), $urandom);
      join
      repeat (mmhpq_pkg::CAPACITY + 2) random_beat(5);

      // Random phases with varied idling, each a fill then a drain
      for (int ph = 0; ph < 4; ph++) begin
         case (ph)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 86; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 86; end
            default: begin send_idle_pct = 18; recv_stall_pct = 18; end
         endcase
         repeat (200) random_beat(75);
         repeat (120) random_beat(25);
      end
      req_valid <= 1'b0;

      while (pending_count != 0) @(posedge clock);
      repeat (50) @(posedge clock);
      if (fail_count == 0) $display("[min_max_heap_priority_queue] OK");
      else $display("[min_max_heap_priority_queue] ERROR");
      $finish;
   end

endmodule
